// ===== hdl/assert_macros.svh =====
// assertion macros shared by the converter rtl
// no dependencies; assertions compile away when ASSERT_OFF is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define HSFC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define HSFC_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define HSFC_ASSERT(label, clk, rst, prop)
`define HSFC_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== hdl/hsfc_pkg.sv =====
// constants and types of the half/single float converter
// no dependencies; imported by hsfc_lzc and half_single_float_convert_core
package hsfc_pkg;

  localparam int HALF_MAN_W  = 10;
  localparam int HALF_EXP_W  = 5;
  localparam int SGL_EXP_W   = 8;
  localparam int SGL_MAN_W   = 23;
  localparam int SHIFT_W     = 4;

  localparam logic [15:0] HALF_SIGN   = 16'h8000;
  localparam logic [15:0] HALF_INF    = 16'h7C00;
  localparam logic [15:0] HALF_QNAN   = 16'h7E00;
  localparam logic [HALF_EXP_W-1:0] HALF_EXP_ALL = 5'h1F;
  localparam logic [SGL_EXP_W-1:0]  SGL_EXP_ALL  = 8'hFF;

  // exponent bias difference and range limits for narrowing
  localparam logic [SGL_EXP_W-1:0] BIAS_DIFF    = 8'd112;
  localparam logic [SGL_EXP_W-1:0] EXP_OVERFLOW = 8'd143;
  // single exponent of a half subnormal before normalization
  localparam logic [SGL_EXP_W-1:0] SUB_BASE_EXP = 8'd113;

  localparam logic FUNC_WIDEN  = 1'b0;
  localparam logic FUNC_NARROW = 1'b1;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_SUB,
    CLS_SPECIAL,
    CLS_NORMAL
  } hsfc_class_t;

  typedef struct packed {
    logic                   func;
    logic                   sign;
    hsfc_class_t            cls;
    logic [HALF_EXP_W-1:0]  ex;
    logic [HALF_MAN_W-1:0]  mn;
    logic [SHIFT_W-1:0]     shift;
    logic [15:0]            narrow;
  } hsfc_stage_t;

endpackage

// ===== hdl/half_single_float_convert_core.sv =====
// top level of the half/single float converter, three register stages
// depends on hsfc_pkg, hsfc_lzc and assert_macros.svh

// Converts IEEE binary16 and binary32 bit patterns. A request is taken on
// any cycle where start is high; busy is always low, so a new request may
// be issued every cycle. func 0 widens the low 16 bits of value from half
// to single exactly; func 1 narrows a single to half by truncation, with
// flush to signed zero below the half normal range, signed infinity on
// overflow and 0x7E00 for any NaN (upper result bits zero). Each result
// appears on result for exactly one cycle with done high, in request
// order; the request is carried through the valid1 and valid2 registers
// and done is registered from valid2. The receiver cannot stall the
// block, so results must be captured when done is high. Pipeline registers:
// input capture, decode with leading-zero count, and final assembly.
`include "assert_macros.svh"

module half_single_float_convert_core
  import hsfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [31:0] value,
  output logic [31:0] result,
  output logic        done
);

  // the pipeline never stalls, so requests are always accepted
  assign busy = 1'b0;

  // stage 1: capture the request
  logic        valid1;
  logic        func1;
  logic [31:0] value1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= start && !busy;
    end
    func1  <= func;
    value1 <= value;
  end

  // stage 2: field decode, classification, narrowing, normalize count
  logic                  valid2;
  hsfc_stage_t           st2;
  hsfc_stage_t           st2_next;
  logic [SHIFT_W-1:0]    lz_shift;

  hsfc_lzc u_lzc (
    .mant  (value1[HALF_MAN_W-1:0]),
    .shift (lz_shift)
  );

  logic [HALF_EXP_W-1:0] h_ex;
  logic [HALF_MAN_W-1:0] h_mn;
  logic [SGL_EXP_W-1:0]  s_ex;
  logic [SGL_MAN_W-1:0]  s_mn;
  logic                  s_sign;

  assign h_ex   = value1[HALF_MAN_W +: HALF_EXP_W];
  assign h_mn   = value1[HALF_MAN_W-1:0];
  assign s_ex   = value1[SGL_MAN_W +: SGL_EXP_W];
  assign s_mn   = value1[SGL_MAN_W-1:0];
  assign s_sign = value1[31];

  always_comb begin
    st2_next.func  = func1;
    st2_next.sign  = value1[15];
    st2_next.ex    = h_ex;
    st2_next.mn    = h_mn;
    st2_next.shift = lz_shift;

    // half input class for widening
    if (h_ex == '0) begin
      st2_next.cls = (h_mn == '0) ? CLS_ZERO : CLS_SUB;
    end else if (h_ex == HALF_EXP_ALL) begin
      st2_next.cls = CLS_SPECIAL;
    end else begin
      st2_next.cls = CLS_NORMAL;
    end

    // narrowing is done in full here
    if (s_ex == SGL_EXP_ALL) begin
      if (s_mn != '0) begin
        st2_next.narrow = HALF_QNAN;
      end else begin
        st2_next.narrow = {s_sign, HALF_INF[14:0]};
      end
    end else if (s_ex <= BIAS_DIFF) begin
      // flush to signed zero, subnormal singles included
      st2_next.narrow = {s_sign, 15'h0};
    end else if (s_ex >= EXP_OVERFLOW) begin
      st2_next.narrow = {s_sign, HALF_INF[14:0]};
    end else begin
      st2_next.narrow = {s_sign, HALF_EXP_W'(s_ex - BIAS_DIFF),
                         s_mn[SGL_MAN_W-1 -: HALF_MAN_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else begin
      valid2 <= valid1;
    end
    st2 <= st2_next;
  end

  // stage 3: assemble the single result and select
  logic [31:0]           result_next;
  logic [SGL_EXP_W-1:0]  sub_exp;
  logic [HALF_MAN_W-1:0] sub_mn;
  logic [SGL_EXP_W-1:0]  norm_exp;
  logic [31:0]           widen;

  // subnormal: shift leading one into the hidden position and drop it
  assign sub_exp  = SUB_BASE_EXP - {{(SGL_EXP_W-SHIFT_W){1'b0}}, st2.shift};
  assign sub_mn   = st2.mn << st2.shift;
  assign norm_exp = {{(SGL_EXP_W-HALF_EXP_W){1'b0}}, st2.ex} + BIAS_DIFF;

  always_comb begin
    case (st2.cls)
      CLS_ZERO:    widen = {st2.sign, 31'h0};
      CLS_SUB:     widen = {st2.sign, sub_exp, sub_mn, 13'h0};
      CLS_SPECIAL: widen = {st2.sign, SGL_EXP_ALL, st2.mn, 13'h0};
      default:     widen = {st2.sign, norm_exp, st2.mn, 13'h0};
    endcase
    if (st2.func == FUNC_NARROW) begin
      result_next = {16'h0, st2.narrow};
    end else begin
      result_next = widen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid2;
    end
    result <= result_next;
  end

  // every accepted request comes out through valid1 and valid2 with done high
  `HSFC_ASSERT(a_latency, clk, rst, (start && !busy) |=> ##2 done)
  `HSFC_ASSERT(a_no_phantom, clk, rst, done |-> $past(start && !busy && !rst, 3))
  // narrowed results keep the upper half clear
  `HSFC_NEVER(a_narrow_upper, clk, rst,
              done && $past(func, 3) && (result[31:16] != 16'h0))
  // a nonzero half never widens to a zero or subnormal single
  `HSFC_NEVER(a_widen_exp, clk, rst,
              done && !$past(func, 3) && ($past(value[14:0], 3) != 15'h0) &&
              (result[30:23] == 8'h0))

endmodule

// ===== hdl/hsfc_lzc.sv =====
// normalize shift count for a half subnormal mantissa
// depends on hsfc_pkg
module hsfc_lzc
  import hsfc_pkg::*;
(
  input  logic [HALF_MAN_W-1:0] mant,
  output logic [SHIFT_W-1:0]    shift
);

  // shift that brings the leading one to the hidden bit position
  always_comb begin
    shift = SHIFT_W'(HALF_MAN_W);
    for (int i = 0; i < HALF_MAN_W; i++) begin
      if (mant[i]) begin
        shift = SHIFT_W'(HALF_MAN_W - i);
      end
    end
  end

endmodule
